[rtl/rthsv_pkg.sv]
// shared constants, types and codes of the rgb to hsv converter
package rthsv_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 13;
  localparam int HUE_Q_BITS   = 10;
  localparam int HUE_SECTOR   = 960;
  localparam int HUE_CIRCLE   = 5760;
  localparam int HUE_NUM_BITS = CHANNEL_BITS + HUE_Q_BITS;
  localparam int SAT_NUM_BITS = 2 * CHANNEL_BITS;
  localparam int DIV_STAGES   = (HUE_Q_BITS > CHANNEL_BITS) ? HUE_Q_BITS : CHANNEL_BITS;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHANNEL_BITS-1:0] CHAN_FULL = {CHANNEL_BITS{1'b1}};

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // classified pixel handed from the front to the divider pipeline
  typedef struct packed {
    sector_e                   sector;
    logic                      neg;
    logic                      gray;
    logic [HUE_NUM_BITS-1:0]   hue_num;
    chan_t                     delta;
    logic [SAT_NUM_BITS-1:0]   sat_num;
    chan_t                     hi;
  } work_t;

  function automatic logic [HUE_BITS-1:0] sector_base(input sector_e sec);
    logic [HUE_BITS-1:0] base;
    case (sec)
      SEC_RED:   base = '0;
      SEC_GREEN: base = HUE_BITS'(2 * HUE_SECTOR);
      SEC_BLUE:  base = HUE_BITS'(4 * HUE_SECTOR);
      default:   base = '0;
    endcase
    return base;
  endfunction

endpackage

[rtl/rthsv_front.sv]
// front end: finds max and min, picks the hue sector and forms both dividends
module rthsv_front (
  input  logic                 start_i,
  input  logic                 busy_i,
  input  rthsv_pkg::chan_t     red_i,
  input  rthsv_pkg::chan_t     green_i,
  input  rthsv_pkg::chan_t     blue_i,
  output logic                 push_o,
  output rthsv_pkg::work_t     word_o
);
  import rthsv_pkg::*;

  chan_t                 hi, lo, mag;
  logic [CHANNEL_BITS:0] diff;
  sector_e               sec;

  always_comb begin
    if (red_i > green_i) begin
      sec = (red_i > blue_i) ? SEC_RED : SEC_BLUE;
    end else begin
      sec = (green_i > blue_i) ? SEC_GREEN : SEC_BLUE;
    end

    hi = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    lo = red_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;

    case (sec)
      SEC_RED:   diff = {1'b0, green_i} - {1'b0, blue_i};
      SEC_GREEN: diff = {1'b0, blue_i} - {1'b0, red_i};
      SEC_BLUE:  diff = {1'b0, red_i} - {1'b0, green_i};
      default:   diff = '0;
    endcase

    // sign and magnitude, the divider works on magnitudes only
    mag = diff[CHANNEL_BITS] ? CHANNEL_BITS'(-diff) : diff[CHANNEL_BITS-1:0];

    word_o.sector  = sec;
    word_o.neg     = diff[CHANNEL_BITS];
    word_o.gray    = (hi == lo);
    word_o.hue_num = HUE_NUM_BITS'(mag) * HUE_NUM_BITS'(HUE_SECTOR);
    word_o.delta   = hi - lo;
    word_o.sat_num = SAT_NUM_BITS'(hi - lo) * SAT_NUM_BITS'(CHAN_FULL);
    word_o.hi      = hi;
  end

  assign push_o = start_i && !busy_i;

endmodule

[rtl/rthsv_queue.sv]
// short queue between the front end and the divider pipeline
module rthsv_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rthsv_pkg::work_t     push_word_i,
  input  logic                 pop_i,
  output logic                 pop_valid_o,
  output rthsv_pkg::work_t     pop_word_o,
  output logic                 full_o
);
  import rthsv_pkg::*;

  work_t                 slot_q [0:QUEUE_DEPTH-1];
  logic [QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]  count_q, count_d;
  logic                  do_pop;

  assign pop_valid_o = (count_q != '0);
  assign full_o      = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign pop_word_o  = slot_q[rd_ptr_q];
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

[rtl/rthsv_back.sv]
// back end: pipelined restoring dividers for hue and saturation, then hue assembly
module rthsv_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  rthsv_pkg::work_t               in_word_i,
  output logic                           pop_o,
  output logic                           valid_o,
  output logic [rthsv_pkg::HUE_BITS-1:0] hue_o,
  output rthsv_pkg::chan_t               saturation_o,
  output rthsv_pkg::chan_t               brightness_o
);
  import rthsv_pkg::*;

  localparam int S = DIV_STAGES;

  logic [S:0]              vld_q;
  logic [HUE_NUM_BITS-1:0] hrem_q [0:S];
  logic [HUE_NUM_BITS-1:0] hrem_d [1:S];
  logic [HUE_Q_BITS-1:0]   hquo_q [0:S];
  logic [HUE_Q_BITS-1:0]   hquo_d [1:S];
  logic [SAT_NUM_BITS-1:0] srem_q [0:S];
  logic [SAT_NUM_BITS-1:0] srem_d [1:S];
  chan_t                   squo_q [0:S];
  chan_t                   squo_d [1:S];
  chan_t                   hden_q [0:S];
  chan_t                   sden_q [0:S];
  sector_e                 sec_q  [0:S];
  logic [S:0]              neg_q, gray_q;

  logic                    valid_q;
  logic [HUE_BITS-1:0]     hue_q, hue_d;
  chan_t                   sat_q, sat_d;
  chan_t                   bright_q;

  // the pipeline never stalls, so every queued word is taken at once
  assign pop_o = in_valid_i;

  always_comb begin
    logic [HUE_NUM_BITS-1:0] hsub;
    logic [SAT_NUM_BITS-1:0] ssub;
    int                      sh;
    for (int s = 0; s < S; s++) begin
      sh = S - 1 - s;
      hrem_d[s+1] = hrem_q[s];
      hquo_d[s+1] = hquo_q[s];
      srem_d[s+1] = srem_q[s];
      squo_d[s+1] = squo_q[s];
      hsub = HUE_NUM_BITS'(hden_q[s]) << sh;
      ssub = SAT_NUM_BITS'(sden_q[s]) << sh;
      // quotient bits shift in msb first, one per stage once the bit is in range
      if (sh < HUE_Q_BITS) begin
        if (hrem_q[s] >= hsub) begin
          hrem_d[s+1] = hrem_q[s] - hsub;
          hquo_d[s+1] = {hquo_q[s][HUE_Q_BITS-2:0], 1'b1};
        end else begin
          hquo_d[s+1] = {hquo_q[s][HUE_Q_BITS-2:0], 1'b0};
        end
      end
      if (sh < CHANNEL_BITS) begin
        if (srem_q[s] >= ssub) begin
          srem_d[s+1] = srem_q[s] - ssub;
          squo_d[s+1] = {squo_q[s][CHANNEL_BITS-2:0], 1'b1};
        end else begin
          squo_d[s+1] = {squo_q[s][CHANNEL_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // sign and sector offset applied to the hue quotient; gray pixels give zero hue and saturation
  always_comb begin
    logic [HUE_BITS-1:0] q;
    logic [HUE_BITS-1:0] base;
    q    = HUE_BITS'(hquo_q[S]);
    base = sector_base(sec_q[S]);
    if (gray_q[S]) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      sat_d = squo_q[S];
      if (!neg_q[S]) begin
        hue_d = base + q;
      end else if (sec_q[S] == SEC_RED && q != '0) begin
        hue_d = HUE_BITS'(HUE_CIRCLE) - q;
      end else begin
        hue_d = base - q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      vld_q   <= {vld_q[S-1:0], in_valid_i};
      valid_q <= vld_q[S];
    end
  end

  always_ff @(posedge clk_i) begin
    hrem_q[0] <= in_word_i.hue_num;
    hquo_q[0] <= '0;
    srem_q[0] <= in_word_i.sat_num;
    squo_q[0] <= '0;
    hden_q[0] <= in_word_i.delta;
    sden_q[0] <= in_word_i.hi;
    sec_q[0]  <= in_word_i.sector;
    neg_q[0]  <= in_word_i.neg;
    gray_q[0] <= in_word_i.gray;
    for (int s = 1; s <= S; s++) begin
      hrem_q[s] <= hrem_d[s];
      hquo_q[s] <= hquo_d[s];
      srem_q[s] <= srem_d[s];
      squo_q[s] <= squo_d[s];
      hden_q[s] <= hden_q[s-1];
      sden_q[s] <= sden_q[s-1];
      sec_q[s]  <= sec_q[s-1];
      neg_q[s]  <= neg_q[s-1];
      gray_q[s] <= gray_q[s-1];
    end
    hue_q    <= hue_d;
    sat_q    <= sat_d;
    bright_q <= sden_q[S];
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

[rtl/rgb_to_hsv_convert_unit.sv]
// top level of the rgb to hsv converter: front end, queue and divider pipeline
//
//   channel   ports                              handshake
//   pixel in  red_i green_i blue_i               start_i high, busy_o low
//   hsv out   hue_o saturation_o brightness_o    valid_o strobe, one cycle
//
// one pixel per clock sustained; each word passes through a queue slot, the
// operand load, one stage per quotient bit of the 10-bit hue divider and the
// output register. reset clears the queue and all valid flags. the receiver
// cannot stall, so the pipeline always advances and busy_o only rises if
// the queue ever fills.
module rgb_to_hsv_convert_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  rthsv_pkg::chan_t               red_i,
  input  rthsv_pkg::chan_t               green_i,
  input  rthsv_pkg::chan_t               blue_i,
  output logic                           valid_o,
  output logic [rthsv_pkg::HUE_BITS-1:0] hue_o,
  output rthsv_pkg::chan_t               saturation_o,
  output rthsv_pkg::chan_t               brightness_o
);
  import rthsv_pkg::*;

  logic  push, pop, pop_valid, full;
  work_t push_word, pop_word;

  assign busy_o = full;

  rthsv_front u_front (
    .start_i (start_i),
    .busy_i  (full),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .push_o  (push),
    .word_o  (push_word)
  );

  rthsv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_word_o  (pop_word),
    .full_o      (full)
  );

  rthsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pop_valid),
    .in_word_i    (pop_word),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  // hue always lands inside one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hue_o < HUE_BITS'(HUE_CIRCLE)))
    else $error("hue out of range");

  // black pixel gives zero hue and zero saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && brightness_o == '0) |-> (hue_o == '0 && saturation_o == '0))
    else $error("black pixel not zero");

  // the back end drains every cycle, so the queue never fills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("queue filled up");

  // a queued word is always taken by the back end in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid |-> pop)
    else $error("queued word not taken");

endmodule
